@@ design/lcg_pkg.sv @@
package lcg_pkg;

	// counter width of the tick timers
	localparam int COUNT_BITS = 16;
	localparam int CFG_BITS   = 16;
	localparam int IDX_BITS   = 2;
	localparam int PHASE_BITS = 3;

	// phase codes as seen on the drive word
	localparam logic [PHASE_BITS-1:0] PH_IDLE      = 3'd0;
	localparam logic [PHASE_BITS-1:0] PH_OPENING   = 3'd1;
	localparam logic [PHASE_BITS-1:0] PH_CAR_HOLD  = 3'd2;
	localparam logic [PHASE_BITS-1:0] PH_CAR_CLOSE = 3'd3;
	localparam logic [PHASE_BITS-1:0] PH_TRN_CLOSE = 3'd4;
	localparam logic [PHASE_BITS-1:0] PH_TRN_HELD  = 3'd5;
	localparam logic [PHASE_BITS-1:0] PH_CLEARING  = 3'd6;

	// register indexes on the config channel
	localparam logic [IDX_BITS-1:0] REG_BLINK_HALF  = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_CAR_HOLD    = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_TRAIN_CLEAR = 2'd2;

	// register reset values
	localparam logic [CFG_BITS-1:0] BLINK_HALF_RST  = 16'd150;
	localparam logic [CFG_BITS-1:0] CAR_HOLD_RST    = 16'd5000;
	localparam logic [CFG_BITS-1:0] TRAIN_CLEAR_RST = 16'd10000;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [CFG_BITS-1:0]   cfg_word_t;
	typedef logic [PHASE_BITS-1:0] phase_t;

	// largest counter value, limits an oversized register
	function automatic count_t lim(input cfg_word_t v);
		logic [31:0] vw;
		logic [31:0] mx;
		begin
			vw = 32'(v);
			mx = 32'((64'd1 << COUNT_BITS) - 64'd1);
			lim = (vw > mx) ? COUNT_BITS'(mx) : COUNT_BITS'(vw);
		end
	endfunction

endpackage

@@ design/lcg_if.sv @@
// sensor word channel
interface lcg_in_if;
	logic valid;
	logic ready;
	logic train_present;
	logic car_present;
	logic gate_closed;
	logic gate_open;

	modport source (output valid, train_present, car_present, gate_closed, gate_open,
		input ready);
	modport sink (input valid, train_present, car_present, gate_closed, gate_open,
		output ready);
endinterface

// drive word channel
interface lcg_out_if;
	logic       valid;
	logic       ready;
	logic       open_motor;
	logic       close_motor;
	logic       open_light;
	logic       close_light;
	logic [2:0] phase;

	modport source (output valid, open_motor, close_motor, open_light, close_light, phase,
		input ready);
	modport sink (input valid, open_motor, close_motor, open_light, close_light, phase,
		output ready);
endinterface

// register write channel
interface lcg_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/level_crossing_gate_sequencer_core.sv @@
// channel   dir  word
// sample    in   train_present, car_present, gate_closed, gate_open (one per tick)
// drive     out  open_motor, close_motor, open_light, close_light, phase
// cfg       in   index, data (0 blink half, 1 car hold, 2 train clear)
//
// one sensor word per cycle unless stalled; its drive word is registered the next cycle
// sequencer state updates at the edge the word is accepted, single pass through the logic
// sample.ready drops only while a drive word waits and drive.ready is low
// arst_n clears state, counters and registers to their defaults; cfg.ready is always high
module level_crossing_gate_sequencer_core
	import lcg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	lcg_in_if.sink     sample,
	lcg_out_if.source  drive,
	lcg_cfg_if.sink    cfg
);

	// config registers
	cfg_word_t blink_half_q;
	cfg_word_t car_hold_q;
	cfg_word_t train_clear_q;

	// sequencer state
	phase_t    phase_q;
	logic [1:0] saved_phase_q;
	count_t    tick_q;
	count_t    saved_hold_q;
	logic      blink_q;
	logic      motor_q;
	logic      pending_q;
	logic      last_train_q;

	// next state
	phase_t    phase_n;
	logic [1:0] saved_phase_n;
	count_t    tick_n;
	count_t    saved_hold_n;
	logic      blink_n;
	logic      motor_n;
	logic      pending_n;

	// output register
	logic      out_valid_q;
	logic      open_motor_q;
	logic      close_motor_q;
	logic      open_light_q;
	logic      close_light_q;
	phase_t    phase_out_q;

	logic      take;
	logic      edge_det;
	phase_t    p;
	count_t    tick_inc;
	count_t    limit;
	logic      done;
	logic      go_enter;
	logic      enter_train;
	logic      tp;

	assign take     = sample.valid && sample.ready;
	assign edge_det = sample.train_present && !last_train_q;
	assign p        = (phase_q > PH_CLEARING) ? PH_IDLE : phase_q;

	// saturating tick and the limit for the current phase
	assign tick_inc = (tick_q != '1) ? tick_q + 1'b1 : tick_q;
	always_comb begin
		case (p)
			PH_CAR_HOLD:              limit = lim(car_hold_q);
			PH_TRN_CLOSE, PH_TRN_HELD: limit = lim(blink_half_q);
			default:                  limit = lim(train_clear_q);
		endcase
	end
	assign done = tick_inc >= limit;

	// phase sequencing
	always_comb begin
		phase_n       = p;
		saved_phase_n = saved_phase_q;
		tick_n        = tick_q;
		saved_hold_n  = saved_hold_q;
		blink_n       = blink_q;
		motor_n       = motor_q;
		pending_n     = pending_q;
		go_enter      = 1'b0;
		enter_train   = 1'b0;
		if (p <= PH_CAR_CLOSE) begin
			if (edge_det) begin
				saved_phase_n = p[1:0];
				saved_hold_n  = tick_q;
				go_enter      = 1'b1;
				enter_train   = 1'b1;
			end else begin
				case (p)
					PH_IDLE: begin
						if (sample.car_present) phase_n = PH_OPENING;
					end
					PH_OPENING: begin
						if (sample.gate_open) begin
							phase_n = PH_CAR_HOLD;
							tick_n  = '0;
						end
					end
					PH_CAR_HOLD: begin
						tick_n = done ? '0 : tick_inc;
						if (done) phase_n = PH_CAR_CLOSE;
					end
					default: begin
						if (sample.gate_closed) phase_n = PH_IDLE;
					end
				endcase
			end
		end else begin
			if (edge_det) pending_n = 1'b1;
			tick_n = done ? '0 : tick_inc;
			if (p == PH_TRN_CLOSE || p == PH_TRN_HELD) begin
				if (done) begin
					if (!blink_q) begin
						blink_n = 1'b1;
					end else if (p == PH_TRN_CLOSE) begin
						go_enter    = 1'b1;
						enter_train = 1'b1;
					end else begin
						go_enter    = 1'b1;
						enter_train = sample.train_present;
					end
				end
			end else if (done) begin
				if (pending_n) begin
					pending_n   = 1'b0;
					go_enter    = 1'b1;
					enter_train = sample.train_present;
				end else begin
					phase_n = {1'b0, saved_phase_q};
					tick_n  = saved_hold_q;
					motor_n = 1'b0;
					blink_n = 1'b0;
				end
			end
		end
		// start a blink cycle, or go to clearing when no train
		if (go_enter) begin
			tick_n  = '0;
			blink_n = 1'b0;
			if (enter_train) begin
				phase_n = sample.gate_closed ? PH_TRN_HELD : PH_TRN_CLOSE;
				motor_n = !sample.gate_closed;
			end else begin
				phase_n = PH_CLEARING;
				motor_n = 1'b0;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			saved_phase_q <= '0;
			tick_q        <= '0;
			saved_hold_q  <= '0;
			blink_q       <= 1'b0;
			motor_q       <= 1'b0;
			pending_q     <= 1'b0;
			last_train_q  <= 1'b0;
		end else if (take) begin
			phase_q       <= phase_n;
			saved_phase_q <= saved_phase_n;
			tick_q        <= tick_n;
			saved_hold_q  <= saved_hold_n;
			blink_q       <= blink_n;
			motor_q       <= motor_n;
			pending_q     <= pending_n;
			last_train_q  <= sample.train_present;
		end
	end

	// config writes
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_half_q  <= BLINK_HALF_RST;
			car_hold_q    <= CAR_HOLD_RST;
			train_clear_q <= TRAIN_CLEAR_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BLINK_HALF:  blink_half_q  <= cfg.data;
				REG_CAR_HOLD:    car_hold_q    <= cfg.data;
				REG_TRAIN_CLEAR: train_clear_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// drive word register
	assign tp = (phase_n == PH_TRN_CLOSE) || (phase_n == PH_TRN_HELD);
	assign sample.ready = !out_valid_q || drive.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (drive.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			open_motor_q  <= (phase_n == PH_OPENING);
			close_motor_q <= (phase_n == PH_CAR_CLOSE) || (tp && motor_n);
			open_light_q  <= (phase_n == PH_OPENING) || (tp && !blink_n);
			close_light_q <= (phase_n == PH_CAR_CLOSE) || (phase_n == PH_CLEARING) ||
				(tp && blink_n);
			phase_out_q   <= phase_n;
		end
	end

	assign drive.valid       = out_valid_q;
	assign drive.open_motor  = open_motor_q;
	assign drive.close_motor = close_motor_q;
	assign drive.open_light  = open_light_q;
	assign drive.close_light = close_light_q;
	assign drive.phase       = phase_out_q;

	// checks
	a_take_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> drive.valid)
		else $error("accepted sensor word left no drive word");

	a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (drive.valid && !drive.ready))
		else $error("sample stalled without backpressure");

	a_open_motor_only_opening: assert property (@(posedge clk) disable iff (!arst_n)
		(drive.valid && drive.open_motor) |-> (drive.phase == PH_OPENING))
		else $error("open motor driven outside opening");

	a_pending_in_train: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> (phase_q == PH_TRN_CLOSE || phase_q == PH_TRN_HELD ||
			phase_q == PH_CLEARING))
		else $error("latched train edge outside a train sequence");

endmodule
